FILE: rtl/core/raycast_wall_column_texturer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the raycast wall column texturer
// Shared property forms; each expects clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RCWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rcwt_pkg.sv
// ----------------------------------------------------------------------------
// rcwt_pkg
// Widths, codes and shared types of the raycast wall column texturer.
// ----------------------------------------------------------------------------
package rcwt_pkg;

  // Fixed-point and texture geometry
  localparam int FRAC_BITS         = 16;
  localparam int TEX_WIDTH         = 64;
  localparam int TEX_HEIGHT        = 64;
  localparam int MAX_SCREEN_HEIGHT = 2048;

  // Field widths
  localparam int COL_W  = 12;
  localparam int ROW_W  = 11;
  localparam int DIST_W = 32;
  localparam int HIT_W  = 26;
  localparam int SIGN_W = 2;
  localparam int TID_W  = 2;
  localparam int LH_W   = 16;
  localparam int H_W    = 12;
  localparam int POS_W  = 32;
  localparam int TEXW_BITS = $clog2(TEX_WIDTH);
  localparam int TEXH_BITS = $clog2(TEX_HEIGHT);
  localparam int HEFF_W    = $clog2(MAX_SCREEN_HEIGHT + 1);

  // Divider: wide enough for H << FRAC and TEX_HEIGHT << FRAC
  localparam int DIV_N_LH = HEFF_W + FRAC_BITS;
  localparam int DIV_N_ST = TEXH_BITS + FRAC_BITS + 1;
  localparam int DIV_N    = (DIV_N_LH > DIV_N_ST) ? DIV_N_LH : DIV_N_ST;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);
  localparam logic [DIV_N-1:0] TEX_DIVIDEND = DIV_N'(TEX_HEIGHT) << FRAC_BITS;

  localparam logic [LH_W-1:0] LH_MAX = {LH_W{1'b1}};

  // Configuration port
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_SCREEN_HEIGHT = '0;
  localparam logic [H_W-1:0] SCREEN_HEIGHT_RESET = H_W'(480);

  // Codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;
  localparam logic [TID_W-1:0] TID_XPOS = 2'd0;
  localparam logic [TID_W-1:0] TID_XNEG = 2'd1;
  localparam logic [TID_W-1:0] TID_YPOS = 2'd2;
  localparam logic [TID_W-1:0] TID_YNEG = 2'd3;
  localparam logic signed [SIGN_W-1:0] SIGN_POS = 2'sd1;

  // Controller to datapath
  typedef struct packed {
    logic start_cap;  // latch a ray hit, launch the height division
    logic tick;       // pixel tick accepted
    logic lh_cap;     // capture saturated line height
    logic geo;        // register rows and offset, launch the step division
    logic step_cap;   // capture the texture step
    logic mul;        // form the starting texture position
    logic hdr;        // load the header result, arm the column
  } rcwt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } rcwt_sts_t;

endpackage

FILE: rtl/core/rcwt_if.sv
// ----------------------------------------------------------------------------
// rcwt_if
// Valid/ready channels: ray hits and ticks in, headers and texels out.
// ----------------------------------------------------------------------------
interface rcwt_in_if import rcwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [COL_W-1:0]         column_index;
  logic                     wall_side;
  logic [DIST_W-1:0]        perp_distance;
  logic [HIT_W-1:0]         hit_position;
  logic signed [SIGN_W-1:0] dir_x_sign;
  logic signed [SIGN_W-1:0] dir_y_sign;

  modport source (output valid, command, column_index, wall_side, perp_distance,
                  hit_position, dir_x_sign, dir_y_sign, input ready);
  modport sink   (input valid, command, column_index, wall_side, perp_distance,
                  hit_position, dir_x_sign, dir_y_sign, output ready);
endinterface

interface rcwt_out_if import rcwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [COL_W-1:0]     screen_x;
  logic [ROW_W-1:0]     screen_y;
  logic [TEXW_BITS-1:0] tex_x;
  logic [TEXH_BITS-1:0] tex_y;
  logic [TID_W-1:0]     texture_id;
  logic [ROW_W-1:0]     draw_start;
  logic [ROW_W-1:0]     draw_end;
  logic [LH_W-1:0]      line_height;
  logic                 last;

  modport source (output valid, kind, screen_x, screen_y, tex_x, tex_y, texture_id,
                  draw_start, draw_end, line_height, last, input ready);
  modport sink   (input valid, kind, screen_x, screen_y, tex_x, tex_y, texture_id,
                  draw_start, draw_end, line_height, last, output ready);
endinterface

FILE: rtl/core/raycast_wall_column_texturer.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// Textured wall column generator for a grid raycaster.
// ----------------------------------------------------------------------------
// A start item carries one ray hit. The block projects the wall height as
// screen_height / distance (Q16.16, saturated at 65535; zero distance gives
// 65535), clamps the first and end rows, picks the texture column from the
// hit fraction (mirrored for x-side rays going +x and y-side rays going -y)
// and the wall texture, then sends one header item. Each later tick item
// returns one texel coordinate for the next row, stepping the texture row in
// Q16.16 and wrapping it to the texture height; the final row has last set.
// Ticks with no open column return nothing; a new start abandons an open
// column. Ticks stream at one per clock while the result side keeps up.
// A start occupies the block until its header is loaded, longer while an
// earlier result still waits in the result register: two passes through
// one shared bit-serial divider (height over distance, then texture height
// over line height), a capture of each quotient, a geometry step that
// launches the second pass, a multiply step for the starting texture
// position and the header load.
// The input is not taken while a start is in progress.
// The single register screen_height sits at byte address 0 (reset 480); a
// value of 0 acts as 1 and values above MAX_SCREEN_HEIGHT are clamped.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer import rcwt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rcwt_in_if.sink           in_if,
  rcwt_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  rcwt_cmd_t      cmd;
  rcwt_sts_t      sts;
  logic [H_W-1:0] screen_height_r;
  logic           reg_hit;

  // Configuration register: written in the access phase; pready is tied high
  assign reg_hit = paddr[ADDR_W-1:2] == REG_SCREEN_HEIGHT;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(screen_height_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= SCREEN_HEIGHT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      screen_height_r <= pwdata[H_W-1:0];
    end
  end

  // Sequencer: owns the input handshake and steps the setup
  rcwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: divider, geometry, row stepping and the result register
  rcwt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .screen_height    (screen_height_r),
    .in_column_index  (in_if.column_index),
    .in_wall_side     (in_if.wall_side),
    .in_perp_distance (in_if.perp_distance),
    .in_hit_position  (in_if.hit_position),
    .in_dir_x_sign    (in_if.dir_x_sign),
    .in_dir_y_sign    (in_if.dir_y_sign),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_kind         (out_if.kind),
    .out_screen_x     (out_if.screen_x),
    .out_screen_y     (out_if.screen_y),
    .out_tex_x        (out_if.tex_x),
    .out_tex_y        (out_if.tex_y),
    .out_texture_id   (out_if.texture_id),
    .out_draw_start   (out_if.draw_start),
    .out_draw_end     (out_if.draw_end),
    .out_line_height  (out_if.line_height),
    .out_last         (out_if.last)
  );

endmodule

FILE: rtl/core/rcwt_div.sv
// ----------------------------------------------------------------------------
// rcwt_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module rcwt_div import rcwt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_N-1:0]  dividend,
  input  logic [DIST_W-1:0] divisor,
  output logic              done,
  output logic [DIV_N-1:0]  quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N-1:0]     q_r;
  logic [DIST_W-1:0]    rem_r;
  logic [DIST_W-1:0]    dsr_r;

  logic [DIST_W:0]   trial;
  logic [DIST_W:0]   diff;
  logic              ge;
  logic [DIST_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[DIV_N-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_N-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/core/rcwt_dp.sv
// ----------------------------------------------------------------------------
// rcwt_dp
// Column datapath: projection, texture setup, row stepping, result register.
// ----------------------------------------------------------------------------
module rcwt_dp import rcwt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rcwt_cmd_t                cmd,
  output rcwt_sts_t                sts,
  input  logic [H_W-1:0]           screen_height,
  input  logic [COL_W-1:0]         in_column_index,
  input  logic                     in_wall_side,
  input  logic [DIST_W-1:0]        in_perp_distance,
  input  logic [HIT_W-1:0]         in_hit_position,
  input  logic signed [SIGN_W-1:0] in_dir_x_sign,
  input  logic signed [SIGN_W-1:0] in_dir_y_sign,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic [COL_W-1:0]         out_screen_x,
  output logic [ROW_W-1:0]         out_screen_y,
  output logic [TEXW_BITS-1:0]     out_tex_x,
  output logic [TEXH_BITS-1:0]     out_tex_y,
  output logic [TID_W-1:0]         out_texture_id,
  output logic [ROW_W-1:0]         out_draw_start,
  output logic [ROW_W-1:0]         out_draw_end,
  output logic [LH_W-1:0]          out_line_height,
  output logic                     out_last
);

  // Column state
  logic [HEFF_W-1:0]    h_r;
  logic                 dist_zero_r;
  logic [LH_W-1:0]      lh_r;
  logic [ROW_W-1:0]     start_r;
  logic [ROW_W-1:0]     end_r;
  logic [LH_W-2:0]      offset_r;
  logic [POS_W-1:0]     tex_step_r;
  logic [POS_W-1:0]     tex_pos_r;
  logic [ROW_W-1:0]     cur_row_r;
  logic [ROW_W-1:0]     end_row_r;
  logic                 active_r;
  logic [TEXW_BITS-1:0] tex_col_r;
  logic [TID_W-1:0]     wall_tex_r;
  logic [COL_W-1:0]     col_num_r;

  // Result register
  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [COL_W-1:0]     out_sx_r;
  logic [ROW_W-1:0]     out_sy_r;
  logic [TEXW_BITS-1:0] out_tx_r;
  logic [TEXH_BITS-1:0] out_ty_r;
  logic [TID_W-1:0]     out_tid_r;
  logic [ROW_W-1:0]     out_ds_r;
  logic [ROW_W-1:0]     out_de_r;
  logic [LH_W-1:0]      out_lh_r;
  logic                 out_last_r;

  logic [HEFF_W-1:0]    h_eff;
  logic                 xpos;
  logic                 ypos;
  logic                 yneg;
  logic [TEXW_BITS-1:0] texx_raw;
  logic [TEXW_BITS-1:0] texx;
  logic [TID_W-1:0]     wall_tex;
  logic                 div_start;
  logic [DIV_N-1:0]     div_dividend;
  logic [DIST_W-1:0]    div_divisor;
  logic                 div_done;
  logic [DIV_N-1:0]     div_q;
  logic [LH_W:0]        hh;
  logic [LH_W:0]        hl;
  logic [LH_W:0]        hv;
  logic [LH_W:0]        end_sum;
  logic [LH_W:0]        start_w;
  logic [LH_W:0]        end_w;
  logic [LH_W:0]        off_w;
  logic [LH_W-1+POS_W-1:0] prod;
  logic                 last_px;
  logic                 pix_load;

  // Clamp the configured height into the usable range
  always_comb begin
    if (screen_height == '0) begin
      h_eff = HEFF_W'(1);
    end else if (int'(screen_height) > MAX_SCREEN_HEIGHT) begin
      h_eff = HEFF_W'(MAX_SCREEN_HEIGHT);
    end else begin
      h_eff = HEFF_W'(screen_height);
    end
  end

  // Texture column and wall texture from the hit
  always_comb begin
    xpos     = in_dir_x_sign == SIGN_POS;
    ypos     = in_dir_y_sign == SIGN_POS;
    yneg     = in_dir_y_sign[SIGN_W-1];
    texx_raw = in_hit_position[FRAC_BITS-1 -: TEXW_BITS];
    if ((!in_wall_side && xpos) || (in_wall_side && yneg)) begin
      texx = ~texx_raw;
    end else begin
      texx = texx_raw;
    end
    if (!in_wall_side) begin
      wall_tex = xpos ? TID_XPOS : TID_XNEG;
    end else begin
      wall_tex = ypos ? TID_YPOS : TID_YNEG;
    end
  end

  // Divider operands: height division on start, step division on geo
  assign div_start    = cmd.start_cap | cmd.geo;
  assign div_dividend = cmd.geo ? TEX_DIVIDEND
                                : DIV_N'({h_eff, {FRAC_BITS{1'b0}}});
  assign div_divisor  = cmd.geo ? DIST_W'(lh_r) : in_perp_distance;

  rcwt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Row geometry from line height
  always_comb begin
    hh      = (LH_W+1)'(h_r >> 1);
    hl      = (LH_W+1)'(lh_r >> 1);
    hv      = (LH_W+1)'(h_r);
    end_sum = hl + hh;
    start_w = (hl < hh) ? (hh - hl) : '0;
    off_w   = (hl < hh) ? '0 : (hl - hh);
    end_w   = (end_sum >= hv) ? (hv - (LH_W+1)'(1)) : end_sum;
  end

  assign prod     = (LH_W-1+POS_W)'(offset_r) * (LH_W-1+POS_W)'(tex_step_r);
  assign last_px  = ({1'b0, cur_row_r} + (ROW_W+1)'(1)) >= {1'b0, end_row_r};
  assign pix_load = cmd.tick && active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_cap) begin
        active_r <= 1'b0;
      end else if (cmd.hdr) begin
        active_r <= end_r > start_r;
      end else if (pix_load && last_px) begin
        active_r <= 1'b0;
      end
      if (cmd.hdr || pix_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_cap) begin
      h_r         <= h_eff;
      dist_zero_r <= in_perp_distance == '0;
      tex_col_r   <= texx;
      wall_tex_r  <= wall_tex;
      col_num_r   <= in_column_index;
    end
    if (cmd.lh_cap) begin
      lh_r <= (dist_zero_r || (|div_q[DIV_N-1:LH_W])) ? LH_MAX : div_q[LH_W-1:0];
    end
    if (cmd.geo) begin
      start_r  <= ROW_W'(start_w);
      end_r    <= ROW_W'(end_w);
      offset_r <= (LH_W-1)'(off_w);
    end
    if (cmd.step_cap) begin
      tex_step_r <= (lh_r == '0) ? '0 : POS_W'(div_q);
    end
    if (cmd.mul) begin
      tex_pos_r <= POS_W'(prod);
    end
    if (cmd.hdr) begin
      cur_row_r  <= start_r;
      end_row_r  <= end_r;
      out_kind_r <= KIND_HEADER;
      out_sx_r   <= col_num_r;
      out_sy_r   <= '0;
      out_tx_r   <= tex_col_r;
      out_ty_r   <= '0;
      out_tid_r  <= wall_tex_r;
      out_ds_r   <= start_r;
      out_de_r   <= end_r;
      out_lh_r   <= lh_r;
      out_last_r <= 1'b0;
    end else if (pix_load) begin
      cur_row_r  <= cur_row_r + ROW_W'(1);
      tex_pos_r  <= tex_pos_r + tex_step_r;
      out_kind_r <= KIND_PIXEL;
      out_sx_r   <= col_num_r;
      out_sy_r   <= cur_row_r;
      out_tx_r   <= tex_col_r;
      out_ty_r   <= tex_pos_r[FRAC_BITS +: TEXH_BITS];
      out_tid_r  <= wall_tex_r;
      out_ds_r   <= '0;
      out_de_r   <= '0;
      out_lh_r   <= '0;
      out_last_r <= last_px;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_screen_x    = out_sx_r;
  assign out_screen_y    = out_sy_r;
  assign out_tex_x       = out_tx_r;
  assign out_tex_y       = out_ty_r;
  assign out_texture_id  = out_tid_r;
  assign out_draw_start  = out_ds_r;
  assign out_draw_end    = out_de_r;
  assign out_line_height = out_lh_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/core/rcwt_ctrl.sv
// ----------------------------------------------------------------------------
// rcwt_ctrl
// Sequencer for column setup; pixel ticks pass straight through when idle.
// ----------------------------------------------------------------------------
module rcwt_ctrl import rcwt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_ready,
  input  rcwt_sts_t sts,
  output rcwt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LH,
    S_GEO,
    S_DIV_ST,
    S_MUL,
    S_HDR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.start_cap = accept && (in_command == CMD_START);
    cmd.tick      = accept && (in_command == CMD_TICK);
    case (state_r)
      S_IDLE: begin
        if (cmd.start_cap) state_nxt = S_DIV_LH;
      end
      S_DIV_LH: begin
        if (sts.div_done) begin
          cmd.lh_cap = 1'b1;
          state_nxt  = S_GEO;
        end
      end
      S_GEO: begin
        cmd.geo   = 1'b1;
        state_nxt = S_DIV_ST;
      end
      S_DIV_ST: begin
        if (sts.div_done) begin
          cmd.step_cap = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        if (sts.out_free) begin
          cmd.hdr   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/rcwt_checker.sv
// ----------------------------------------------------------------------------
// rcwt_checker
// Port-level checks on the texturer, attached by bind.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_texturer_defines.svh"

module rcwt_checker import rcwt_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_command,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_kind,
  input logic [COL_W-1:0]     out_screen_x,
  input logic [ROW_W-1:0]     out_screen_y,
  input logic [TEXW_BITS-1:0] out_tex_x,
  input logic [TEXH_BITS-1:0] out_tex_y,
  input logic [TID_W-1:0]     out_texture_id,
  input logic [ROW_W-1:0]     out_draw_start,
  input logic [ROW_W-1:0]     out_draw_end,
  input logic [LH_W-1:0]      out_line_height,
  input logic                 out_last
);

  logic [COL_W+2*ROW_W+TEXW_BITS+TEXH_BITS+TID_W+ROW_W+LH_W+1:0] out_bus;
  logic start_acc;
  logic hdr_vis;
  logic pix_vis;

  assign out_bus   = {out_kind, out_screen_x, out_screen_y, out_tex_x, out_tex_y,
                      out_texture_id, out_draw_start, out_draw_end, out_line_height,
                      out_last};
  assign start_acc = in_valid && in_ready && (in_command == CMD_START);
  assign hdr_vis   = out_valid && (out_kind == KIND_HEADER);
  assign pix_vis   = out_valid && (out_kind == KIND_PIXEL);

  // Hold a stalled result
  `RCWT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "result changed while stalled")
  // Headers carry no pixel row, texel row or last flag
  `RCWT_ASSERT_NOW(a_hdr_fields, hdr_vis, out_screen_y == '0 && out_tex_y == '0 && !out_last, "header carries pixel fields")
  // Pixels carry no column geometry
  `RCWT_ASSERT_NOW(a_pix_fields, pix_vis, out_draw_start == '0 && out_draw_end == '0 && out_line_height == '0, "pixel carries header fields")
  // A start occupies the setup sequencer, so the next cycle takes nothing
  `RCWT_ASSERT_NEXT(a_start_busy, start_acc, !in_ready, "input taken during column setup")

endmodule

bind raycast_wall_column_texturer rcwt_checker u_rcwt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_command      (in_if.command),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_kind        (out_if.kind),
  .out_screen_x    (out_if.screen_x),
  .out_screen_y    (out_if.screen_y),
  .out_tex_x       (out_if.tex_x),
  .out_tex_y       (out_if.tex_y),
  .out_texture_id  (out_if.texture_id),
  .out_draw_start  (out_if.draw_start),
  .out_draw_end    (out_if.draw_end),
  .out_line_height (out_if.line_height),
  .out_last        (out_if.last)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Raycast wall column texturer testbench
// Sends ray hit starts and pixel ticks through the valid/ready input channel
// and sets screen_height over the APB port. A behavioral column tracker
// computes every header and texel the block must return. A checker compares
// each accepted result, field by field, with the oldest pending one.
// ----------------------------------------------------------------------------
module testbench;
  import rcwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is busy this long per start (two divider passes plus the tail).
  localparam int BUSY_CYCLES  = 2 * DIV_N + 5;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int MAX_REPORTS  = 10;

  // One input item, field for field as on the channel.
  typedef struct packed {
    logic                     command;
    logic [COL_W-1:0]         column_index;
    logic                     wall_side;
    logic [DIST_W-1:0]        perp_distance;
    logic [HIT_W-1:0]         hit_position;
    logic [SIGN_W-1:0]        dir_x_sign;
    logic [SIGN_W-1:0]        dir_y_sign;
  } ray_item_t;

  // One result item: a column header or a textured pixel.
  typedef struct packed {
    logic                 kind;
    logic [COL_W-1:0]     screen_x;
    logic [ROW_W-1:0]     screen_y;
    logic [TEXW_BITS-1:0] tex_x;
    logic [TEXH_BITS-1:0] tex_y;
    logic [TID_W-1:0]     texture_id;
    logic [ROW_W-1:0]     draw_start;
    logic [ROW_W-1:0]     draw_end;
    logic [LH_W-1:0]      line_height;
    logic                 last;
  } texel_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rcwt_in_if  in_bus();
  rcwt_out_if out_bus();

  raycast_wall_column_texturer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Column tracker state: a shadow of the register and of the open column.
  logic [H_W-1:0]       screen_rows = SCREEN_HEIGHT_RESET;
  bit                   col_open    = 1'b0;
  logic [ROW_W-1:0]     row_at      = '0;
  logic [ROW_W-1:0]     row_end     = '0;
  logic [POS_W-1:0]     tex_pos     = '0;
  logic [POS_W-1:0]     tex_step    = '0;
  logic [TEXW_BITS-1:0] tex_col     = '0;
  logic [TID_W-1:0]     wall_tex    = '0;
  logic [COL_W-1:0]     col_num     = '0;

  texel_t      pending_texels[$];
  int          mismatch_count  = 0;
  int          results_caused  = 0;
  longint      cycle_count     = 0;
  bit          pace_on         = 1'b1;  // sender gaps enabled
  bit          stall_on        = 1'b1;  // receiver stalls enabled

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Column tracker
  // --------------------------------------------------------------------------

  // Visible rows as the block uses them: 0 acts as 1, clamp at the maximum.
  function automatic longint unsigned eff_rows();
    if (screen_rows == 0)
      return 1;
    if (screen_rows > MAX_SCREEN_HEIGHT)
      return MAX_SCREEN_HEIGHT;
    return screen_rows;
  endfunction

  // Advance the column state by one accepted item; return 1 with the result
  // it causes, or 0 for a tick that finds no open column.
  function automatic bit column_step(input ray_item_t it, output texel_t r);
    longint unsigned h, ray_dist, lh, half_h, half_l, row0, rown, texx, offs;
    bit xpos, ypos, yneg;
    r = '0;
    if (it.command == CMD_START) begin
      h        = eff_rows();
      ray_dist = it.perp_distance;
      // Zero distance saturates; otherwise project and clip to 16 bits.
      if (ray_dist == 0) begin
        lh = LH_MAX;
      end else begin
        lh = (h << FRAC_BITS) / ray_dist;
        if (lh > LH_MAX)
          lh = LH_MAX;
      end
      half_h = h >> 1;
      half_l = lh >> 1;
      row0   = (half_l < half_h) ? half_h - half_l : 0;
      rown   = half_l + half_h;
      if (rown >= h)
        rown = h - 1;

      // Only the hit fraction picks the texture column.
      texx = ((it.hit_position % (64'd1 << FRAC_BITS)) * TEX_WIDTH) >> FRAC_BITS;
      // Only +1 counts as positive; any pattern with the top bit set is negative.
      xpos = (it.dir_x_sign == SIGN_POS);
      ypos = (it.dir_y_sign == SIGN_POS);
      yneg = it.dir_y_sign[SIGN_W-1];
      // Mirror the column where the texture would show reversed.
      if ((it.wall_side == 1'b0 && xpos) || (it.wall_side == 1'b1 && yneg))
        texx = TEX_WIDTH - texx - 1;
      if (it.wall_side == 1'b0)
        wall_tex = xpos ? TID_XPOS : TID_XNEG;
      else
        wall_tex = ypos ? TID_YPOS : TID_YNEG;

      // Zero line height gives a zero step and an empty column.
      tex_step = (lh == 0) ? '0 : POS_W'((64'(TEX_HEIGHT) << FRAC_BITS) / lh);
      offs     = row0 + half_l - half_h;
      tex_pos  = POS_W'(offs * tex_step);

      tex_col  = texx[TEXW_BITS-1:0];
      col_num  = it.column_index;
      row_at   = row0[ROW_W-1:0];
      row_end  = rown[ROW_W-1:0];
      col_open = (rown > row0);

      r.kind        = KIND_HEADER;
      r.screen_x    = col_num;
      r.tex_x       = tex_col;
      r.texture_id  = wall_tex;
      r.draw_start  = row_at;
      r.draw_end    = row_end;
      r.line_height = lh[LH_W-1:0];
      return 1'b1;
    end

    // Tick while idle: nothing comes back.
    if (!col_open)
      return 1'b0;

    r.kind       = KIND_PIXEL;
    r.screen_x   = col_num;
    r.screen_y   = row_at;
    r.tex_x      = tex_col;
    r.tex_y      = tex_pos[FRAC_BITS +: TEXH_BITS];
    r.texture_id = wall_tex;
    r.last       = (({1'b0, row_at} + 1'b1) >= {1'b0, row_end});
    tex_pos      = tex_pos + tex_step;
    row_at       = row_at + 1'b1;
    if (r.last)
      col_open = 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic string texel_str(input texel_t t);
    return $sformatf({"kind=%0d x=%0d y=%0d tx=%0d ty=%0d tid=%0d ",
                      "ds=%0d de=%0d lh=%0d last=%0d"},
                     t.kind, t.screen_x, t.screen_y, t.tex_x, t.tex_y, t.texture_id,
                     t.draw_start, t.draw_end, t.line_height, t.last);
  endfunction

  task automatic count_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s", $realtime, msg);
  endtask

  // Take each accepted result and compare it with the oldest pending one.
  always @(posedge clk) begin : check_results
    texel_t got;
    texel_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.kind        = out_bus.kind;
      got.screen_x    = out_bus.screen_x;
      got.screen_y    = out_bus.screen_y;
      got.tex_x       = out_bus.tex_x;
      got.tex_y       = out_bus.tex_y;
      got.texture_id  = out_bus.texture_id;
      got.draw_start  = out_bus.draw_start;
      got.draw_end    = out_bus.draw_end;
      got.line_height = out_bus.line_height;
      got.last        = out_bus.last;
      if (pending_texels.size() == 0) begin
        count_mismatch({"unexpected result: ", texel_str(got)});
      end else begin
        want = pending_texels.pop_front();
        if (got !== want)
          count_mismatch({"result differs\n  expected ", texel_str(want),
                          "\n  actual   ", texel_str(got)});
      end
    end
  end

  // Receiver: draw a stall per item (none when stall_on is clear), then hold ready until the item moves.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      repeat (stall_on ? $urandom_range(0, 11) : 0) begin
        @(negedge clk);
        out_bus.ready = 1'b0;
      end
      @(negedge clk);
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one item after a random gap (none when pace_on is clear); update the tracker on acceptance.
  task automatic send_item(input ray_item_t it);
    texel_t r;
    repeat (pace_on ? $urandom_range(0, 11) : 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.command       = it.command;
    in_bus.column_index  = it.column_index;
    in_bus.wall_side     = it.wall_side;
    in_bus.perp_distance = it.perp_distance;
    in_bus.hit_position  = it.hit_position;
    in_bus.dir_x_sign    = it.dir_x_sign;
    in_bus.dir_y_sign    = it.dir_y_sign;
    in_bus.valid         = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    if (column_step(it, r)) begin
      pending_texels.push_back(r);
      results_caused++;
    end
  endtask

  // Drop valid, wait for every pending result, then let the block go quiet.
  task automatic settle_block();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_texels.size() != 0)
      @(posedge clk);
    repeat (BUSY_CYCLES + 8) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_W'(REG_SCREEN_HEIGHT) << 2;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write screen_height while idle and read it back.
  task automatic set_screen_rows(input logic [H_W-1:0] value);
    logic [APB_DW-1:0] rd;
    settle_block();
    apb_xfer(1'b1, APB_DW'(value), rd);
    screen_rows = value;
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DW'(value))
      count_mismatch($sformatf("screen_height reads %0d, wrote %0d", rd, value));
  endtask

  function automatic ray_item_t rand_ray(input logic cmd);
    ray_item_t r;
    r.command       = cmd;
    r.column_index  = $urandom;
    r.wall_side     = $urandom;
    r.perp_distance = $urandom;
    r.hit_position  = $urandom;
    r.dir_x_sign    = $urandom;
    r.dir_y_sign    = $urandom;
    return r;
  endfunction

  function automatic ray_item_t ray_start(input logic [COL_W-1:0] col, input logic side,
                                         input logic [DIST_W-1:0] ray_dist,
                                         input logic [HIT_W-1:0] hit,
                                         input logic [SIGN_W-1:0] dx,
                                         input logic [SIGN_W-1:0] dy);
    ray_item_t r;
    r = '{CMD_START, col, side, ray_dist, hit, dx, dy};
    return r;
  endfunction

  // Distance that projects to about the given line height at the current
  // screen height; a target of zero lands past the point where height hits 0.
  function automatic logic [DIST_W-1:0] dist_for_height(input int rows);
    longint unsigned span;
    span = eff_rows() << FRAC_BITS;
    if (rows == 0)
      return $urandom_range(32'hFFFF_FFFF, 32'(span + 1));
    return DIST_W'(span / rows + $urandom_range(0, 255));
  endfunction

  // Start a column, tick through up to max_ticks of its pixels, then send
  // some surplus ticks (they land on an idle block when the column is done).
  task automatic run_column(input ray_item_t start_item, input int max_ticks,
                            input int extra);
    int n;
    send_item(start_item);
    n = col_open ? int'(row_end) - int'(row_at) : 0;
    if (n > max_ticks)
      n = max_ticks;
    repeat (n + extra) send_item(rand_ray(CMD_TICK));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every sign pattern on both sides, and the corner cases,
  // all at the reset screen height of 480.
  task automatic test_directed();
    // tick with no column open
    send_item(rand_ray(CMD_TICK));
    // zero distance saturates the height; abandon it after two rows
    send_item(ray_start(12'd0, 1'b0, 32'd0, 26'd0, 2'b01, 2'b00));
    send_item(rand_ray(CMD_TICK));
    send_item(rand_ray(CMD_TICK));
    // huge distance: zero height, header only, then an idle tick
    send_item(ray_start(12'hFFF, 1'b1, 32'hFFFF_FFFF, 26'h3FF_FFFF, 2'b11, 2'b01));
    send_item(rand_ray(CMD_TICK));
    // distance of one lsb saturates; remaining x and y sign patterns
    send_item(ray_start(12'd1, 1'b0, 32'd1, 26'h000_FFFF, 2'b11, 2'b10));
    send_item(ray_start(12'd2, 1'b0, 32'h0001_0000, 26'h3FF_0000, 2'b00, 2'b11));
    send_item(ray_start(12'd3, 1'b0, 32'h8000_0000, 26'h000_8000, 2'b10, 2'b01));
    send_item(ray_start(12'd4, 1'b1, 32'h0010_0000, 26'h123_4567, 2'b01, 2'b11));
    send_item(ray_start(12'd5, 1'b1, 32'h0100_0000, 26'h2AA_AAAA, 2'b00, 2'b10));
    send_item(ray_start(12'd6, 1'b1, 32'h0000_8000, 26'h155_5555, 2'b10, 2'b00));
    // four-row column run to its flagged last pixel, plus one surplus tick
    run_column(ray_start(12'd2047, 1'b1, 32'd7864320, 26'h000_C000, 2'b11, 2'b01),
               4096, 1);
    // height one: single-row line that still draws nothing
    send_item(ray_start(12'd2048, 1'b0, 32'd31457280, 26'h000_4000, 2'b01, 2'b01));
    // height three: two rows
    run_column(ray_start(12'd100, 1'b0, 32'd10485760, 26'h000_2000, 2'b00, 2'b11),
               4096, 0);
  endtask

  // Register extremes: 0 and 1 act as one row, values past the maximum clamp.
  task automatic test_height_range();
    logic [H_W-1:0] heights[8];
    ray_item_t it;
    heights = '{12'd0, 12'd1, 12'd2, 12'd16, 12'd2048, 12'd4095, 12'd2047,
                H_W'($urandom_range(3, 2046))};
    foreach (heights[i]) begin
      set_screen_rows(heights[i]);
      pace_on  = (i % 2 == 0);
      stall_on = (i % 3 != 0);
      // full saturated column at small heights, a clipped one elsewhere
      it = rand_ray(CMD_START);
      it.perp_distance = '0;
      run_column(it, (eff_rows() <= 16) ? 4096 : 24, 1);
      it = rand_ray(CMD_START);
      it.perp_distance = dist_for_height($urandom_range(1, 24));
      run_column(it, 4096, 1);
    end
  endtask

  // Mostly well-formed columns with random content, some abandoned, plus
  // stray ticks, random distances and near-zero distances.
  task automatic test_random_columns(input int goal);
    logic [H_W-1:0] heights[6];
    ray_item_t it;
    int base;
    heights = '{12'd4095, 12'd1, 12'd480, 12'd2048,
                H_W'($urandom_range(2, 4095)), 12'd0};
    foreach (heights[i]) begin
      set_screen_rows(heights[i]);
      base = results_caused;
      while (results_caused - base < goal / 6) begin
        pace_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 15))
          0: send_item(rand_ray(CMD_TICK));
          1: run_column(rand_ray(CMD_START), $urandom_range(0, 3), 0);
          2: begin
            // hold off until the block has returned everything
            settle_block();
            it = rand_ray(CMD_START);
            it.perp_distance = $urandom_range(0, 3);
            run_column(it, $urandom_range(0, 30), 0);
          end
          default: begin
            it = rand_ray(CMD_START);
            it.perp_distance = dist_for_height($urandom_range(0, 40));
            run_column(it, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : 4096,
                       $urandom_range(0, 2));
          end
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.command       = CMD_START;
    in_bus.column_index  = '0;
    in_bus.wall_side     = 1'b0;
    in_bus.perp_distance = '0;
    in_bus.hit_position  = '0;
    in_bus.dir_x_sign    = '0;
    in_bus.dir_y_sign    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_height_range();
    test_random_columns(840);

    // drain, then let any last activity show up
    settle_block();
    if (mismatch_count == 0 && pending_texels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
